FILE: design/brl_pkg.sv
// brl_pkg: widths, codes, defaults and sequencer states of the block-encoded range lookup
// no dependencies; used by brl_if.sv and block_encoded_range_lookup_core.sv
package brl_pkg;

    localparam int CMD_W    = 1;
    localparam int ENTRY_W  = 10;
    localparam int SIZE_W   = 32;
    localparam int OFFSET_W = 48;
    localparam int EXP_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_BLOCKS_DEF  = 1024;
    localparam int ALIGN_BYTES_DEF = 16;

    localparam logic [EXP_W-1:0]    EXP_RESET   = 5'd16;
    localparam logic [OFFSET_W-1:0] TOTAL_RESET = 48'd0;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX  = 48'hFFFF_FFFF_FFFF;

    // input commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_EXP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_RAW_SIZE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CHECK,
        ST_SH_CNT,
        ST_SH_FIRST,
        ST_SH_LAST,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

FILE: design/brl_if.sv
// brl_if: request, response and configuration channels of the range lookup
// depends on brl_pkg for field widths
interface brl_req_if;
    logic                              valid;
    logic                              ready;
    logic [brl_pkg::CMD_W-1:0]         cmd;
    logic [brl_pkg::ENTRY_W-1:0]       entry_index;
    logic [brl_pkg::SIZE_W-1:0]        entry_size;
    logic [brl_pkg::OFFSET_W-1:0]      raw_offset;
    logic [brl_pkg::OFFSET_W-1:0]      raw_length;

    modport source (output valid, cmd, entry_index, entry_size, raw_offset, raw_length,
                    input ready);
    modport sink   (input valid, cmd, entry_index, entry_size, raw_offset, raw_length,
                    output ready);
endinterface

interface brl_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic [brl_pkg::OFFSET_W-1:0]      encoded_start;
    logic [brl_pkg::OFFSET_W-1:0]      encoded_end;

    modport source (output valid, ok, encoded_start, encoded_end, input ready);
    modport sink   (input valid, ok, encoded_start, encoded_end, output ready);
endinterface

interface brl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [brl_pkg::CFG_IDX_W-1:0]     index;
    logic [brl_pkg::OFFSET_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/block_encoded_range_lookup_core.sv
// block_encoded_range_lookup_core: block size table and raw-to-encoded range lookup
// depends on brl_pkg and the channel interfaces in brl_if.sv

// The block holds one item at a time on the request channel. A write item
// (cmd 0) has its entry size rounded up to a multiple of ALIGN_BYTES (which
// must be a power of two) with one add and a mask, and the aligned size is
// stored in the table in the cycle after acceptance. A write to a slot at or
// beyond MAX_BLOCKS is dropped and the block is ready at once. A query item
// (cmd 1) runs a range check, three passes through one shared barrel shifter
// for the block count, first block and last block, then walks the size table
// from entry 0 up to the last covering block, one entry per cycle through a
// single registered read port, with one saturating 48-bit adder; rejected
// queries skip the walk. The walk is what sets the query time. The result
// sits in an output register, so a finished result may wait on the response
// channel while the block goes ready again; a new result waits only if the
// previous one was not taken.
// Configuration writes are always accepted, and are meant for idle periods.
// Table entries that were never written read as whatever the memory holds.
module block_encoded_range_lookup_core #(
    parameter int MAX_BLOCKS  = brl_pkg::MAX_BLOCKS_DEF,
    parameter int ALIGN_BYTES = brl_pkg::ALIGN_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    brl_req_if.sink   req,
    brl_rsp_if.source rsp,
    brl_cfg_if.sink   cfg
);

    // table index and walk position widths
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int WORD_W = brl_pkg::SIZE_W + 1;
    localparam int SUM_W  = brl_pkg::OFFSET_W + 1;
    localparam int EXT_W  = 17;

    localparam logic [WORD_W-1:0]    ALIGN_WD   = WORD_W'(ALIGN_BYTES);
    localparam logic [WORD_W-1:0]    ALIGN_LOW  = ALIGN_WD - WORD_W'(1);
    localparam logic [WORD_W-1:0]    ALIGN_MASK = ~ALIGN_LOW;
    localparam logic [brl_pkg::OFFSET_W-1:0] MAX_BLK_W = brl_pkg::OFFSET_W'(MAX_BLOCKS);
    localparam logic [EXT_W-1:0]     MAX_BLK_X = EXT_W'(MAX_BLOCKS);

    // sequencer
    brl_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [brl_pkg::EXP_W-1:0]    exp_reg, exp_next;
    logic [brl_pkg::OFFSET_W-1:0] total_reg, total_next;

    // captured item
    logic [brl_pkg::SIZE_W-1:0]   esz_reg, esz_next;
    logic [IDX_W-1:0]             waddr_reg, waddr_next;
    logic [brl_pkg::OFFSET_W-1:0] off_reg, off_next;
    logic [brl_pkg::OFFSET_W-1:0] len_reg, len_next;

    // range decode
    logic [SUM_W-1:0]             end_reg, end_next;
    logic [brl_pkg::OFFSET_W-1:0] count_reg, count_next;
    logic [brl_pkg::OFFSET_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0]             firstw_reg, firstw_next;
    logic [IDX_W-1:0]             last_reg, last_next;
    logic [SUM_W-1:0]             end_sum;
    logic [SUM_W-1:0]             blk_size;
    logic [SUM_W-1:0]             shift_in;
    logic [SUM_W-1:0]             shift_out;
    logic [brl_pkg::OFFSET_W-1:0] last_full;

    // table walk
    logic [IDX_W-1:0]             iss_reg, iss_next;
    logic                         issuing_reg, issuing_next;
    logic                         dv_reg, dv_next;
    logic [IDX_W-1:0]             cur_reg, cur_next;
    logic [CNT_W-1:0]             cur_plus;
    logic [brl_pkg::OFFSET_W-1:0] acc_reg, acc_next;
    logic [brl_pkg::OFFSET_W-1:0] start_reg, start_next;
    logic [SUM_W-1:0]             acc_sum;
    logic [brl_pkg::OFFSET_W-1:0] acc_sat;
    logic                         okp_reg, okp_next;

    // size table
    logic [WORD_W-1:0]            mem [MAX_BLOCKS];
    logic [WORD_W-1:0]            rd_data_reg;
    logic                         mem_we;
    logic [WORD_W-1:0]            mem_wdata;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic                         out_ok_reg, out_ok_next;
    logic [brl_pkg::OFFSET_W-1:0] out_start_reg, out_start_next;
    logic [brl_pkg::OFFSET_W-1:0] out_end_reg, out_end_next;

    logic [EXT_W-1:0]             idx_ext;
    logic                         req_fire;
    logic                         rsp_fire;

    assign req.ready         = (state_reg == brl_pkg::ST_IDLE);
    assign req_fire          = req.valid && req.ready;
    assign rsp.valid         = out_valid_reg;
    assign rsp.ok            = out_ok_reg;
    assign rsp.encoded_start = out_start_reg;
    assign rsp.encoded_end   = out_end_reg;
    assign rsp_fire          = out_valid_reg && rsp.ready;
    assign cfg.ready         = 1'b1;

    assign idx_ext = EXT_W'(req.entry_index);

    // shared barrel shifter: block count, first block, last block
    assign blk_size = SUM_W'(1) << exp_reg;
    always_comb
    begin
        if (state_reg == brl_pkg::ST_SH_CNT)
        begin
            shift_in = {1'b0, total_reg} + blk_size - SUM_W'(1);
        end
        else if (state_reg == brl_pkg::ST_SH_FIRST)
        begin
            shift_in = {1'b0, off_reg};
        end
        else
        begin
            shift_in = end_reg - SUM_W'(1);
        end
    end
    assign shift_out = shift_in >> exp_reg;
    assign last_full = shift_out[brl_pkg::OFFSET_W-1:0];

    assign end_sum = {1'b0, off_reg} + {1'b0, len_reg};

    // saturating accumulate of the aligned entry just read
    assign acc_sum  = {1'b0, acc_reg} + SUM_W'(rd_data_reg);
    assign acc_sat  = (acc_sum > {1'b0, brl_pkg::OFFSET_MAX}) ? brl_pkg::OFFSET_MAX
                                                             : acc_sum[brl_pkg::OFFSET_W-1:0];
    assign cur_plus = CNT_W'(cur_reg) + CNT_W'(1);

    // aligned size, stored at the end of a write; round up to the power-of-two alignment
    assign mem_wdata = ({1'b0, esz_reg} + ALIGN_LOW) & ALIGN_MASK;

    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        total_next     = total_reg;
        esz_next       = esz_reg;
        waddr_next     = waddr_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        end_next       = end_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        firstw_next    = firstw_reg;
        last_next      = last_reg;
        iss_next       = iss_reg;
        issuing_next   = issuing_reg;
        dv_next        = 1'b0;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        start_next     = start_reg;
        okp_next       = okp_reg;
        mem_we         = 1'b0;
        out_valid_next = rsp_fire ? 1'b0 : out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;

        if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == brl_pkg::CFG_BLOCK_SIZE_EXP)
            begin
                exp_next = cfg.data[brl_pkg::EXP_W-1:0];
            end
            else if (cfg.index == brl_pkg::CFG_TOTAL_RAW_SIZE)
            begin
                total_next = cfg.data;
            end
        end

        unique case (state_reg)
            brl_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    esz_next    = req.entry_size;
                    waddr_next  = idx_ext[IDX_W-1:0];
                    off_next    = req.raw_offset;
                    len_next    = req.raw_length;
                    if (req.cmd == brl_pkg::CMD_QUERY)
                    begin
                        state_next = brl_pkg::ST_CHECK;
                    end
                    else if (idx_ext < MAX_BLK_X)
                    begin
                        state_next = brl_pkg::ST_WRITE;
                    end
                end
            end
            brl_pkg::ST_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = brl_pkg::ST_IDLE;
            end
            brl_pkg::ST_CHECK:
            begin
                end_next = end_sum;
                if (end_sum > {1'b0, total_reg} || end_sum == '0)
                begin
                    okp_next   = 1'b0;
                    state_next = brl_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = brl_pkg::ST_SH_CNT;
                end
            end
            brl_pkg::ST_SH_CNT:
            begin
                count_next = shift_out[brl_pkg::OFFSET_W-1:0];
                state_next = brl_pkg::ST_SH_FIRST;
            end
            brl_pkg::ST_SH_FIRST:
            begin
                first_next = shift_out[brl_pkg::OFFSET_W-1:0];
                state_next = brl_pkg::ST_SH_LAST;
            end
            brl_pkg::ST_SH_LAST:
            begin
                if (first_reg > count_reg || last_full > count_reg || last_full >= MAX_BLK_W)
                begin
                    okp_next   = 1'b0;
                    state_next = brl_pkg::ST_FINISH;
                end
                else
                begin
                    // first never exceeds last + 1 here, so it fits the walk counter
                    last_next    = last_full[IDX_W-1:0];
                    firstw_next  = first_reg[CNT_W-1:0];
                    iss_next     = '0;
                    issuing_next = 1'b1;
                    acc_next     = '0;
                    start_next   = '0;
                    okp_next     = 1'b1;
                    state_next   = brl_pkg::ST_WALK;
                end
            end
            brl_pkg::ST_WALK:
            begin
                if (issuing_reg)
                begin
                    dv_next  = 1'b1;
                    cur_next = iss_reg;
                    iss_next = iss_reg + 1'b1;
                    if (iss_reg == last_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (dv_reg)
                begin
                    acc_next = acc_sat;
                    // start offset is the sum of all entries ahead of the first block
                    if (cur_plus == firstw_reg)
                    begin
                        start_next = acc_sat;
                    end
                    if (cur_reg == last_reg)
                    begin
                        state_next = brl_pkg::ST_FINISH;
                    end
                end
            end
            brl_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = okp_reg;
                    out_start_next = okp_reg ? start_reg : '0;
                    out_end_next   = okp_reg ? acc_reg : '0;
                    state_next     = brl_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brl_pkg::ST_IDLE;
            exp_reg       <= brl_pkg::EXP_RESET;
            total_reg     <= brl_pkg::TOTAL_RESET;
            iss_reg       <= '0;
            issuing_reg   <= 1'b0;
            dv_reg        <= 1'b0;
            okp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            total_reg     <= total_next;
            iss_reg       <= iss_next;
            issuing_reg   <= issuing_next;
            dv_reg        <= dv_next;
            okp_reg       <= okp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        esz_reg       <= esz_next;
        waddr_reg     <= waddr_next;
        off_reg       <= off_next;
        len_reg       <= len_next;
        end_reg       <= end_next;
        count_reg     <= count_next;
        first_reg     <= first_next;
        firstw_reg    <= firstw_next;
        last_reg      <= last_next;
        cur_reg       <= cur_next;
        acc_reg       <= acc_next;
        start_reg     <= start_next;
        out_ok_reg    <= out_ok_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
    end

    // size table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[iss_reg];
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.cmd == brl_pkg::CMD_QUERY)) |=> !req.ready)
        else $error("query accepted but block still ready");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brl_pkg::ST_WALK && dv_reg) |-> (cur_reg <= last_reg))
        else $error("table walk ran past the last block");

    a_align_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brl_pkg::ST_WRITE) |->
            (mem_wdata >= {1'b0, esz_reg}) && ((mem_wdata - {1'b0, esz_reg}) < ALIGN_WD))
        else $error("aligned size out of range");

    a_ok_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ok) |-> (rsp.encoded_start <= rsp.encoded_end))
        else $error("encoded start beyond encoded end");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> (rsp.encoded_start == '0 && rsp.encoded_end == '0))
        else $error("rejected item carries nonzero offsets");
`endif

endmodule
